// File: rtl/bacp_pkg.sv
// Shared types, constants and code-set function for the bill acceptor code parser.
`default_nettype none
package bacp_pkg;

   localparam int NUM_CHANNELS = 16;
   localparam int TABLE_DEPTH  = 16;
   localparam int QUEUE_DEPTH  = 2;

   localparam logic [7:0] CODE_BUSY     = 8'd120;
   localparam logic [7:0] CODE_NOT_BUSY = 8'd121;
   localparam logic [7:0] CODE_REJECT   = 8'd20;
   localparam logic [7:0] CODE_CH_FIRST = 8'd1;
   localparam logic [7:0] CODE_CH_LAST  = 8'd16;

   localparam logic [31:0] TOTAL_MAX = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      ACT_BYTE  = 2'd0,
      ACT_LOAD  = 2'd1,
      ACT_CLEAR = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      OP_NONE   = 2'd0,
      OP_CREDIT = 2'd1,
      OP_LOAD   = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [7:0]  rx_byte;
      logic [3:0]  channel_index;
      logic [23:0] bill_value;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] total_value;
      logic        credited;
      logic [4:0]  credited_channel;
      logic        byte_known;
   } rsp_payload_type;

   // Classified command handed from the front to the back.
   typedef struct packed {
      op_type      op;
      logic [3:0]  index;
      logic [23:0] value;
      logic [4:0]  channel;
      logic        known;
   } cmd_type;

   function automatic logic code_is_known(input logic [7:0] b);
      logic hit;
      hit = 1'b0;
      if (b >= 8'd1 && b <= 8'd16) hit = 1'b1;
      if (b == 8'd20 || b == 8'd30 || b == 8'd40 || b == 8'd50) hit = 1'b1;
      if (b == 8'd60 || b == 8'd70 || b == 8'd80) hit = 1'b1;
      if (b == CODE_BUSY || b == CODE_NOT_BUSY) hit = 1'b1;
      if (b >= 8'd131 && b <= 8'd146) hit = 1'b1;
      if (b >= 8'd151 && b <= 8'd166) hit = 1'b1;
      if (b >= 8'd170 && b <= 8'd173) hit = 1'b1;
      if (b == 8'd182 || b == 8'd184 || b == 8'd185) hit = 1'b1;
      if (b >= 8'd190 && b <= 8'd193) hit = 1'b1;
      if (b == 8'd255) hit = 1'b1;
      return hit;
   endfunction

endpackage
`default_nettype wire

// File: rtl/bacp_front.sv
// Front end: accepts transactions, tracks the parse phase and classifies each item.
`default_nettype none
module bacp_front
   import bacp_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire logic            req_ready,
   input  wire req_payload_type req_payload,
   output logic                 push,
   output cmd_type              cmd
);

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_BUSY   = 2'd1,
      PH_READY  = 2'd2,
      PH_REJECT = 2'd3
   } phase_type;

   phase_type phase_ff, phase_in;
   logic [7:0] b;
   logic       known;
   logic       is_channel;

   assign b          = req_payload.rx_byte;
   assign known      = code_is_known(b);
   assign is_channel = (b >= CODE_CH_FIRST) && (b <= CODE_CH_LAST) &&
                       (b <= 8'(NUM_CHANNELS));
   assign push       = req_valid && req_ready;

   always_comb begin
      phase_in    = phase_ff;
      cmd.op      = OP_NONE;
      cmd.index   = req_payload.channel_index;
      cmd.value   = req_payload.bill_value;
      cmd.channel = b[4:0];
      cmd.known   = 1'b0;
      case (req_payload.action)
         ACT_BYTE: begin
            if (known) begin
               cmd.known = 1'b1;
               case (phase_ff)
                  PH_IDLE: begin
                     phase_in = (b == CODE_BUSY) ? PH_BUSY : PH_IDLE;
                  end
                  PH_BUSY: begin
                     if (b == CODE_NOT_BUSY) phase_in = PH_READY;
                     else if (b == CODE_REJECT) phase_in = PH_REJECT;
                     else phase_in = PH_IDLE;
                  end
                  PH_READY: begin
                     phase_in = PH_IDLE;
                     if (is_channel) begin
                        cmd.op    = OP_CREDIT;
                        cmd.index = 4'(b - CODE_CH_FIRST);
                     end
                  end
                  PH_REJECT: begin
                     // swallow the not-busy that trails a reject
                     if (b == CODE_NOT_BUSY) phase_in = PH_IDLE;
                     else phase_in = (b == CODE_BUSY) ? PH_BUSY : PH_IDLE;
                  end
                  default: phase_in = PH_IDLE;
               endcase
            end
         end
         ACT_LOAD: begin
            if ({1'b0, req_payload.channel_index} < 5'(NUM_CHANNELS)) cmd.op = OP_LOAD;
         end
         ACT_CLEAR: cmd.op = OP_CLEAR;
         default:   cmd.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else if (push) begin
         phase_ff <= phase_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/bacp_queue.sv
// Two-entry command queue between the front and back ends.
`default_nettype none
module bacp_queue
   import bacp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   input  wire logic    pop,
   output logic         full,
   output logic         not_empty,
   output cmd_type      head_cmd
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   cmd_type              slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]       count_ff, count_in;

   assign full      = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_cmd  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule
`default_nettype wire

// File: rtl/bacp_back.sv
// Back end: value table, saturating total and the registered result stage.
`default_nettype none
module bacp_back
   import bacp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    cmd_valid,
   input  wire cmd_type cmd,
   output logic         pop,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_payload_type rsp_payload
);

   logic [23:0]     table_ff [TABLE_DEPTH];
   logic [31:0]     total_ff, total_in;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_ff, rsp_in;
   logic [23:0]     entry;
   logic [32:0]     sum;

   // advance when the result register is empty or being taken
   assign pop         = cmd_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign entry       = table_ff[cmd.index];
   assign sum         = {1'b0, total_ff} + {9'd0, entry};

   always_comb begin
      total_in                = total_ff;
      rsp_in.credited         = 1'b0;
      rsp_in.credited_channel = '0;
      rsp_in.byte_known       = cmd.known;
      case (cmd.op)
         OP_CREDIT: begin
            if (entry != '0) begin
               total_in                = sum[32] ? TOTAL_MAX : sum[31:0];
               rsp_in.credited         = 1'b1;
               rsp_in.credited_channel = cmd.channel;
            end
         end
         OP_CLEAR: total_in = '0;
         default:  total_in = total_ff;
      endcase
      rsp_in.total_value = total_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         total_ff     <= '0;
         for (int i = 0; i < TABLE_DEPTH; i++) table_ff[i] <= '0;
      end else begin
         if (pop) begin
            rsp_valid_ff <= 1'b1;
            total_ff     <= total_in;
            if (cmd.op == OP_LOAD) table_ff[cmd.index] <= cmd.value;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) rsp_ff <= rsp_in;
   end

endmodule
`default_nettype wire

// File: rtl/bill_acceptor_code_parser.sv
// Top level of the bill acceptor code parser: front end, command queue, back end.
//
// req_* carries one transaction per item: a received validator byte, a table
// load or a total clear. rsp_* returns exactly one result per item, in order:
// the running total after the item, whether a channel was credited (and
// which), and whether the byte is in the known code set.
// Both channels use valid/ready; a transaction moves when both are high.
// With nothing queued, an item is written into a queue entry when accepted
// and then moves from that entry into the result register.
// Throughput: one item per cycle while rsp_ready is high; the front end
// tracks the busy/not-busy/channel phase, the back end does one table read
// and one 32-bit saturating add per cycle.
// A two-entry queue sits between the front and back ends, and the result
// stage is a register, so a new item is taken while a result waits. When
// rsp_ready stays low the result register and both queue entries fill, and
// then req_ready drops until a result is taken.
// Reset clears the parse phase to idle, all table entries to zero, the total
// to zero and empties the queue and result register.
`default_nettype none
module bill_acceptor_code_parser
   import bacp_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire req_payload_type req_payload,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output rsp_payload_type      rsp_payload
);

   logic    push;
   logic    pop;
   logic    full;
   logic    not_empty;
   cmd_type front_cmd;
   cmd_type head_cmd;

   assign req_ready = !full;

   bacp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .push        (push),
      .cmd         (front_cmd)
   );

   bacp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (front_cmd),
      .pop       (pop),
      .full      (full),
      .not_empty (not_empty),
      .head_cmd  (head_cmd)
   );

   bacp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (not_empty),
      .cmd         (head_cmd),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire
